// File: sv/hmm_pkg.sv
// Shared types and constants for the handheld memory map decoder.
package hmm_pkg;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_LOAD_CART = 2'd2,
    OP_LOAD_BOOT = 2'd3
  } op_t;

  // Which store supplies the read byte of a transfer.
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_BOOT,
    SRC_CART,
    SRC_EXT,
    SRC_WORK,
    SRC_HRAM
  } src_t;

  localparam logic [15:0] BOOT_EXIT_ADDR = 16'h0100;
  localparam logic [15:0] SERIAL_ADDR    = 16'hFF01;
  localparam logic [15:0] WORK_END_ADDR  = 16'hFE00;
  localparam logic        START_IN_BOOT_RST = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        video_request;
    logic        video_is_write;
    logic [15:0] video_address;
    logic [7:0]  video_wdata;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        boot_active;
  } out_item_t;

  // Result-side information that travels with a transfer while its memory read completes.
  typedef struct packed {
    src_t        src;
    logic        video_request;
    logic        video_is_write;
    logic [15:0] video_address;
    logic [7:0]  video_wdata;
    logic        serial_valid;
    logic [7:0]  serial_byte;
  } route_t;

  // Store write enables and the overlay clear, produced by the decoder.
  typedef struct packed {
    logic cart_we;
    logic boot_we;
    logic ext_we;
    logic work_we;
    logic hram_we;
    logic ovl_clr;
  } mem_ctl_t;

endpackage

// File: sv/handheld_memory_map_decoder_top.sv
// Top level of the handheld memory map decoder: stores, overlay flag and result register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   hmm_pkg::in_item_t
//   out_     output     out_valid/out_stall hmm_pkg::out_item_t
//   cfg_     input      cfg_we              start_in_boot (1 bit)
//
// One transfer is taken every cycle while in_stall is low; its result passes through the read stage
// and then the output register, once the registered read of the addressed store has completed.
// Synchronous reset clears the control state and sets the boot overlay; the stores
// are not cleared and hold whatever was last written.
// A stalled result holds the output register; the read stage behind it then stalls
// the input, so at most two transfers are in flight.
module handheld_memory_map_decoder_top #(
  parameter int ROM_DEPTH  = 32768,
  parameter int BOOT_DEPTH = 256,
  parameter int RAM_DEPTH  = 8192,
  parameter int HRAM_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hmm_pkg::in_item_t  in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output hmm_pkg::out_item_t out_payload,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int ROM_AW  = $clog2(ROM_DEPTH);
  localparam int BOOT_AW = $clog2(BOOT_DEPTH);
  localparam int RAM_AW  = $clog2(RAM_DEPTH);
  localparam int HRAM_AW = $clog2(HRAM_DEPTH);

  hmm_pkg::route_t    dec_route;
  hmm_pkg::mem_ctl_t  dec_ctl;

  logic               start_in_boot_r;
  logic               start_in_boot_nxt;
  logic               overlay_r;
  logic               overlay_nxt;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  hmm_pkg::route_t    s1_route_r;
  logic               s1_boot_r;

  logic               out_valid_r;
  logic               out_valid_nxt;
  hmm_pkg::out_item_t out_r;
  hmm_pkg::out_item_t out_nxt;

  logic               accept;
  logic               s1_adv;

  logic [7:0]         cart_rdata;
  logic [7:0]         boot_rdata;
  logic [7:0]         ext_rdata;
  logic [7:0]         work_rdata;
  logic [7:0]         hram_rdata;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  hmm_decode u_decode (
    .item    (in_payload),
    .overlay (overlay_r),
    .route   (dec_route),
    .ctl     (dec_ctl)
  );

  hmm_ram #(.DEPTH(ROM_DEPTH)) u_cart (
    .clk   (clk),
    .we    (accept && dec_ctl.cart_we),
    .re    (accept && (dec_route.src == hmm_pkg::SRC_CART)),
    .addr  (in_payload.address[ROM_AW-1:0]),
    .wdata (in_payload.data),
    .rdata (cart_rdata)
  );

  hmm_ram #(.DEPTH(BOOT_DEPTH)) u_boot (
    .clk   (clk),
    .we    (accept && dec_ctl.boot_we),
    .re    (accept && (dec_route.src == hmm_pkg::SRC_BOOT)),
    .addr  (in_payload.address[BOOT_AW-1:0]),
    .wdata (in_payload.data),
    .rdata (boot_rdata)
  );

  hmm_ram #(.DEPTH(RAM_DEPTH)) u_ext (
    .clk   (clk),
    .we    (accept && dec_ctl.ext_we),
    .re    (accept && (dec_route.src == hmm_pkg::SRC_EXT)),
    .addr  (in_payload.address[RAM_AW-1:0]),
    .wdata (in_payload.data),
    .rdata (ext_rdata)
  );

  hmm_ram #(.DEPTH(RAM_DEPTH)) u_work (
    .clk   (clk),
    .we    (accept && dec_ctl.work_we),
    .re    (accept && (dec_route.src == hmm_pkg::SRC_WORK)),
    .addr  (in_payload.address[RAM_AW-1:0]),
    .wdata (in_payload.data),
    .rdata (work_rdata)
  );

  hmm_ram #(.DEPTH(HRAM_DEPTH)) u_hram (
    .clk   (clk),
    .we    (accept && dec_ctl.hram_we),
    .re    (accept && (dec_route.src == hmm_pkg::SRC_HRAM)),
    .addr  (in_payload.address[HRAM_AW-1:0]),
    .wdata (in_payload.data),
    .rdata (hram_rdata)
  );

  // At reset both the overlay and the boot setting load START_IN_BOOT_RST; a cfg write changes
  // the setting, not the running overlay.
  assign start_in_boot_nxt = !rst_n  ? hmm_pkg::START_IN_BOOT_RST :
                             cfg_we  ? cfg_wdata : start_in_boot_r;
  assign overlay_nxt       = (accept && dec_ctl.ovl_clr) ? 1'b0 : overlay_r;

  assign s1_valid_nxt  = accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_comb begin
    out_nxt.video_request  = s1_route_r.video_request;
    out_nxt.video_is_write = s1_route_r.video_is_write;
    out_nxt.video_address  = s1_route_r.video_address;
    out_nxt.video_wdata    = s1_route_r.video_wdata;
    out_nxt.serial_valid   = s1_route_r.serial_valid;
    out_nxt.serial_byte    = s1_route_r.serial_byte;
    out_nxt.boot_active    = s1_boot_r;
    case (s1_route_r.src)
      hmm_pkg::SRC_BOOT: out_nxt.read_data = boot_rdata;
      hmm_pkg::SRC_CART: out_nxt.read_data = cart_rdata;
      hmm_pkg::SRC_EXT:  out_nxt.read_data = ext_rdata;
      hmm_pkg::SRC_WORK: out_nxt.read_data = work_rdata;
      hmm_pkg::SRC_HRAM: out_nxt.read_data = hram_rdata;
      default:           out_nxt.read_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    start_in_boot_r <= start_in_boot_nxt;
    if (!rst_n) begin
      overlay_r   <= start_in_boot_nxt;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      overlay_r   <= overlay_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_route_r <= dec_route;
      s1_boot_r  <= overlay_nxt;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

// File: sv/hmm_ram.sv
// Byte-wide single-port RAM with a registered read.
module hmm_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/hmm_decode.sv
// Address and operation decode of one bus transfer.
module hmm_decode (
  input  hmm_pkg::in_item_t item,
  input  logic              overlay,
  output hmm_pkg::route_t   route,
  output hmm_pkg::mem_ctl_t ctl
);

  logic [15:0] a;
  logic        is_rom;
  logic        is_vram;
  logic        is_ext;
  logic        is_work;
  logic        is_hram;
  logic        is_io_video;

  assign a           = item.address;
  assign is_rom      = !a[15];
  assign is_vram     = (a[15:13] == 3'b100);
  assign is_ext      = (a[15:13] == 3'b101);
  assign is_work     = (a[15:14] == 2'b11) && (a < hmm_pkg::WORK_END_ADDR);
  assign is_hram     = (a[15:7] == 9'h1FF);
  // FF40-FF7F: the I/O page below high RAM with the upper nibble of the low byte at 4 or more.
  assign is_io_video = (a[15:8] == 8'hFF) && !a[7] && a[6];

  always_comb begin
    route = '0;
    ctl   = '0;
    case (hmm_pkg::op_t'(item.operation))
      hmm_pkg::OP_READ: begin
        if (is_rom) begin
          if (overlay && (a[15:8] == 8'h00)) begin
            route.src = hmm_pkg::SRC_BOOT;
          end else begin
            route.src   = hmm_pkg::SRC_CART;
            ctl.ovl_clr = overlay && (a == hmm_pkg::BOOT_EXIT_ADDR);
          end
        end else if (is_vram || is_io_video) begin
          route.video_request = 1'b1;
          route.video_address = a;
        end else if (is_ext) begin
          route.src = hmm_pkg::SRC_EXT;
        end else if (is_work) begin
          route.src = hmm_pkg::SRC_WORK;
        end else if (is_hram) begin
          route.src = hmm_pkg::SRC_HRAM;
        end
      end
      hmm_pkg::OP_WRITE: begin
        if (is_vram || is_io_video) begin
          route.video_request  = 1'b1;
          route.video_is_write = 1'b1;
          route.video_address  = a;
          route.video_wdata    = item.data;
        end else if (is_ext) begin
          ctl.ext_we = 1'b1;
        end else if (is_work) begin
          ctl.work_we = 1'b1;
        end else if (is_hram) begin
          ctl.hram_we = 1'b1;
        end else if (a == hmm_pkg::SERIAL_ADDR) begin
          route.serial_valid = 1'b1;
          route.serial_byte  = item.data;
        end
      end
      hmm_pkg::OP_LOAD_CART: begin
        ctl.cart_we = 1'b1;
      end
      hmm_pkg::OP_LOAD_BOOT: begin
        ctl.boot_we = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule
